>>> rtl/core/cawu_pkg.sv
// ----------------------------------------------------------------------------
// CIGAR walker package
// Shared widths, payload word types, operation codes and saturating helpers
// for the CIGAR alignment walker.
// ----------------------------------------------------------------------------
package cawu_pkg;

    // Internal widths of the run length, the read-side counters and the reference cursor.
    localparam int LEN_BITS  = 20;
    localparam int READ_BITS = 16;
    localparam int REF_BITS  = 32;

    // Fixed widths of the result word fields.
    localparam int OP_LEN_W  = 20;
    localparam int OFFSET_W  = 16;
    localparam int TOTAL_W   = 16;

    // Intermediate widths: run length times ten plus a digit, and sums.
    localparam int RUN_MUL_W = LEN_BITS + 4;
    localparam int RSUM_W    = ((LEN_BITS > READ_BITS) ? LEN_BITS : READ_BITS) + 1;
    localparam int REFSUM_W  = REF_BITS + 1;

    localparam logic [LEN_BITS-1:0]  LEN_MAX  = '1;
    localparam logic [READ_BITS-1:0] READ_MAX = '1;
    localparam logic [REF_BITS-1:0]  REF_MAX  = '1;

    // ASCII codes of the recognized characters.
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_M    = 8'h4D;
    localparam logic [7:0] CH_I    = 8'h49;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_H    = 8'h48;

    typedef enum logic [2:0] {
        OP_MATCH = 3'd0,
        OP_INS   = 3'd1,
        OP_DEL   = 3'd2,
        OP_SOFT  = 3'd3,
        OP_HARD  = 3'd4,
        OP_OTHER = 3'd5
    } cawu_op_t;

    typedef struct packed {
        logic [7:0]  cigar_char;
        logic        new_read;
        logic [31:0] read_ref_start;
    } cawu_in_t;

    typedef struct packed {
        logic [2:0]          op_code;
        logic [OP_LEN_W-1:0] op_length;
        logic [31:0]         seg_ref_start;
        logic [OFFSET_W-1:0] seg_read_offset;
        logic [TOTAL_W-1:0]  matched_total;
    } cawu_out_t;

    // Walker state carried from one character to the next.
    typedef struct packed {
        logic [LEN_BITS-1:0]  run_number;
        logic [REF_BITS-1:0]  ref_cursor;
        logic [READ_BITS-1:0] read_cursor;
        logic [READ_BITS-1:0] match_sum;
    } cawu_state_t;

    // Read-side counter plus a run length, clamped at the counter maximum.
    function automatic logic [READ_BITS-1:0] sat_read(
        input logic [READ_BITS-1:0] a,
        input logic [LEN_BITS-1:0]  b
    );
        logic [RSUM_W-1:0] s;
        s = RSUM_W'(a) + RSUM_W'(b);
        if (s > RSUM_W'(READ_MAX)) begin
            return READ_MAX;
        end
        return s[READ_BITS-1:0];
    endfunction

    // Reference cursor plus a run length, clamped at the top of the range.
    function automatic logic [REF_BITS-1:0] sat_ref(
        input logic [REF_BITS-1:0] a,
        input logic [LEN_BITS-1:0] b
    );
        logic [REFSUM_W-1:0] s;
        s = REFSUM_W'(a) + REFSUM_W'(b);
        if (s > REFSUM_W'(REF_MAX)) begin
            return REF_MAX;
        end
        return s[REF_BITS-1:0];
    endfunction

endpackage

>>> rtl/core/cigar_alignment_walker_unit.sv
// ----------------------------------------------------------------------------
// CIGAR alignment walker
// Walks a CIGAR string one character per word and emits one segment word
// per non-digit character, with its length, reference start and read offset.
// ----------------------------------------------------------------------------
//  Channel | Ports                     | Word
//  --------+---------------------------+-----------------------------------
//  input   | s_valid, s_ready, s_data  | cigar_char, new_read, read_ref_start
//  result  | m_valid, m_ready, m_data  | op_code, op_length, seg_ref_start,
//          |                           | seg_read_offset, matched_total
//
// One character is taken every cycle unless an operation character is held up;
// a character is registered in the input register, its result word in the result register.
// The walker state updates in the same cycle the character leaves the input
// register, so each character sees the state left by the one before it.
// A digit never waits on the result side; an operation character waits only
// while the result register holds a word that has not been taken.
// Reset (aresetn low, synchronous) clears both valid flags and the state.
// ----------------------------------------------------------------------------
module cigar_alignment_walker_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cawu_pkg::cawu_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cawu_pkg::cawu_out_t m_data
);
    import cawu_pkg::*;

    cawu_in_t    in_reg;
    logic        in_valid_reg;
    cawu_state_t state_reg;
    cawu_state_t state_next;
    cawu_out_t   out_reg;
    logic        m_valid_reg;
    logic        m_valid_next;
    cawu_out_t   res_word;
    logic        res_valid;
    logic        advance;

    cawu_step u_step (
        .in_word   (in_reg),
        .state_cur (state_reg),
        .state_new (state_next),
        .res_word  (res_word),
        .res_valid (res_valid)
    );

    // The held word moves on when it is a digit or the result slot is free.
    assign advance = in_valid_reg && (!res_valid || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (advance && res_valid) begin
            m_valid_next = 1'b1;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Walker state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (advance && res_valid) begin
            out_reg <= res_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // An operation character that moves on always leaves a result word.
    a_op_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res_valid |=> m_valid_reg)
        else $error("operation character produced no result word");

    // A digit moving on never creates a result word by itself.
    a_digit_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !res_valid && (!m_valid_reg || m_ready) |=> !m_valid_reg)
        else $error("digit produced a result word");

    // The first digit of a new read leaves a single-digit run length.
    a_new_read_run: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_reg.new_read && !res_valid |=> state_reg.run_number < LEN_BITS'(10))
        else $error("run length not restarted on new read");

    // Within a read the read cursor never moves backward.
    a_read_cursor_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_reg.new_read
            |=> state_reg.read_cursor >= $past(state_reg.read_cursor))
        else $error("read cursor moved backward");

endmodule

>>> rtl/core/cawu_step.sv
// ----------------------------------------------------------------------------
// CIGAR walker step
// Combinational update for one character: builds the decimal run length,
// or closes the run and forms the segment word while moving the cursors.
// ----------------------------------------------------------------------------
module cawu_step (
    input  cawu_pkg::cawu_in_t    in_word,
    input  cawu_pkg::cawu_state_t state_cur,
    output cawu_pkg::cawu_state_t state_new,
    output cawu_pkg::cawu_out_t   res_word,
    output logic                  res_valid
);
    import cawu_pkg::*;

    cawu_state_t              base;
    logic                     is_digit;
    logic [RUN_MUL_W-1:0]     run_mul;
    logic [LEN_BITS-1:0]      run_digit;
    cawu_op_t                 op;

    // A new read clears the counters and loads the reference start first.
    always_comb begin
        base = state_cur;
        if (in_word.new_read) begin
            base.run_number  = '0;
            base.ref_cursor  = in_word.read_ref_start;
            base.read_cursor = '0;
            base.match_sum   = '0;
        end
    end

    // Decimal accumulation: run * 10 + digit as two shifts and two adds, clamped at LEN_MAX.
    always_comb begin
        is_digit = (in_word.cigar_char inside {[CH_ZERO:CH_NINE]});
        run_mul  = (RUN_MUL_W'(base.run_number) << 3) + (RUN_MUL_W'(base.run_number) << 1)
                 + RUN_MUL_W'(in_word.cigar_char[3:0]);
        if (run_mul > RUN_MUL_W'(LEN_MAX)) begin
            run_digit = LEN_MAX;
        end else begin
            run_digit = run_mul[LEN_BITS-1:0];
        end
    end

    // Operation decode and cursor moves.
    always_comb begin
        state_new = base;
        op        = OP_OTHER;
        if (is_digit) begin
            state_new.run_number = run_digit;
        end else begin
            state_new.run_number = '0;
            case (in_word.cigar_char)
                CH_M: begin
                    op = OP_MATCH;
                    state_new.ref_cursor  = sat_ref(base.ref_cursor, base.run_number);
                    state_new.read_cursor = sat_read(base.read_cursor, base.run_number);
                    state_new.match_sum   = sat_read(base.match_sum, base.run_number);
                end
                CH_I: begin
                    op = OP_INS;
                    state_new.read_cursor = sat_read(base.read_cursor, base.run_number);
                end
                CH_D: begin
                    op = OP_DEL;
                    state_new.ref_cursor = sat_ref(base.ref_cursor, base.run_number);
                end
                CH_S: begin
                    op = OP_SOFT;
                    state_new.read_cursor = sat_read(base.read_cursor, base.run_number);
                end
                CH_H: begin
                    op = OP_HARD;
                end
                default: begin
                    op = OP_OTHER;
                end
            endcase
        end
    end

    // Segment word: positions before the move, total after it.
    always_comb begin
        res_valid                = !is_digit;
        res_word.op_code         = op;
        res_word.op_length       = OP_LEN_W'(base.run_number);
        res_word.seg_ref_start   = base.ref_cursor;
        res_word.seg_read_offset = OFFSET_W'(base.read_cursor);
        res_word.matched_total   = TOTAL_W'(state_new.match_sum);
    end

endmodule

>>> bench/cigar_alignment_walker_unit_tb.sv
// ----------------------------------------------------------------------------
// CIGAR alignment walker testbench
// Sends CIGAR characters through the walker and checks every segment word
// against an in-bench predictor of the run length, cursors and match total.
// A short directed table covers the operations and the saturation corners.
// Random reads follow under three idling profiles, with one long result-side
// hold-off that backs the walker up into its input.
// ----------------------------------------------------------------------------
module cigar_alignment_walker_unit_tb;
    import cawu_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;

    // Characters outside the recognized set used by the directed table.
    localparam logic [7:0] CH_X       = "X";
    localparam logic [7:0] CH_LOWER_M = "m";
    localparam logic [7:0] CH_SLASH   = "/";
    localparam logic [7:0] CH_COLON   = ":";
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TOP     = 8'hFF;

    typedef struct {
        logic [7:0]  ch;
        bit          first;
        logic [31:0] start;
        bit          typed;
        cawu_out_t   seg;
    } char_row_t;

    typedef struct {
        cawu_in_t  word;
        bit        typed;
        cawu_out_t seg;
    } char_item_t;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    cawu_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    cawu_out_t m_data;

    // Walker state as predicted from the accepted characters.
    logic [LEN_BITS-1:0]  run_len   = '0;
    logic [REF_BITS-1:0]  ref_pos   = '0;
    logic [READ_BITS-1:0] read_pos  = '0;
    logic [READ_BITS-1:0] match_len = '0;

    char_item_t in_flight[$];
    cawu_out_t  expected_segments[$];
    int         mismatches     = 0;
    int         chars_sent     = 0;
    int         send_idle_pct  = 0;
    int         recv_idle_pct  = 0;
    bit         long_hold_req  = 1'b0;
    bit         long_hold_done = 1'b0;
    int         hold_left      = 0;
    int         stuck_cycles   = 0;

    logic [7:0] op_letters [5] = '{CH_M, CH_I, CH_D, CH_S, CH_H};

    // Operations first, then a saturated run length on a fresh read, then stray characters.
    char_row_t directed_rows [25] = '{
        '{CH_M,       1'b0, 32'd0,          1'b1, '{OP_MATCH, 20'd0, 32'd0, 16'd0, 16'd0}},
        '{CH_H,       1'b1, 32'hFFFF_FFFF,  1'b1,
          '{OP_HARD, 20'd0, 32'hFFFF_FFFF, 16'd0, 16'd0}},
        '{"2",        1'b1, 32'hFFFF_FFF0,  1'b0, '0},
        '{"0",        1'b0, 32'd0,          1'b0, '0},
        '{CH_D,       1'b0, 32'd0,          1'b0, '0},
        '{CH_M,       1'b0, 32'd0,          1'b0, '0},
        '{"9",        1'b1, 32'd0,          1'b0, '0},
        '{"9",        1'b0, 32'd0,          1'b0, '0},
        '{"9",        1'b0, 32'd0,          1'b0, '0},
        '{"9",        1'b0, 32'd0,          1'b0, '0},
        '{"9",        1'b0, 32'd0,          1'b0, '0},
        '{"9",        1'b0, 32'd0,          1'b0, '0},
        '{"9",        1'b0, 32'd0,          1'b0, '0},
        '{CH_M,       1'b0, 32'd0,          1'b1,
          '{OP_MATCH, 20'hFFFFF, 32'd0, 16'd0, 16'hFFFF}},
        '{"3",        1'b0, 32'd0,          1'b0, '0},
        '{CH_I,       1'b0, 32'd0,          1'b0, '0},
        '{"4",        1'b0, 32'd0,          1'b0, '0},
        '{CH_S,       1'b0, 32'd0,          1'b0, '0},
        '{CH_X,       1'b0, 32'd0,          1'b0, '0},
        '{CH_TOP,     1'b0, 32'd0,          1'b0, '0},
        '{CH_NUL,     1'b0, 32'd0,          1'b0, '0},
        '{CH_SLASH,   1'b0, 32'd0,          1'b0, '0},
        '{CH_COLON,   1'b0, 32'd0,          1'b0, '0},
        '{CH_I,       1'b1, 32'd5,          1'b1, '{OP_INS, 20'd0, 32'd5, 16'd0, 16'd0}},
        '{CH_LOWER_M, 1'b0, 32'd0,          1'b0, '0}
    };

    cigar_alignment_walker_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Appends a character word to the list of words offered to the walker.
    function automatic void append_char_item(char_item_t item);
        in_flight.insert(in_flight.size(), item);
    endfunction

    // Appends a segment word to the list of words expected from the walker.
    function automatic void append_segment(cawu_out_t seg);
        expected_segments.insert(expected_segments.size(), seg);
    endfunction

    // Sum clamped at a ceiling, computed wide enough to never wrap.
    function automatic logic [63:0] clamp_add(logic [63:0] base, logic [63:0] step,
                                              logic [63:0] ceiling);
        logic [63:0] total;
        total = base + step;
        return (total > ceiling) ? ceiling : total;
    endfunction

    // Advances the predicted walker state by one character; returns 1 and the
    // segment word when the character closes a run.
    function automatic bit walk_cigar_char(input cawu_in_t w, output cawu_out_t seg);
        logic [63:0]         grown;
        logic [7:0]          digit;
        logic [LEN_BITS-1:0] len;
        cawu_op_t            op;
        if (w.new_read) begin
            run_len   = '0;
            ref_pos   = w.read_ref_start;
            read_pos  = '0;
            match_len = '0;
        end
        if (w.cigar_char >= CH_ZERO && w.cigar_char <= CH_NINE) begin
            digit   = w.cigar_char - CH_ZERO;
            grown   = 64'(run_len) * 64'd10 + 64'(digit);
            run_len = (grown > 64'(LEN_MAX)) ? LEN_MAX : grown[LEN_BITS-1:0];
            return 1'b0;
        end
        len                 = run_len;
        run_len             = '0;
        seg.op_length       = len;
        seg.seg_ref_start   = ref_pos;
        seg.seg_read_offset = read_pos;
        case (w.cigar_char)
            CH_M: begin
                op        = OP_MATCH;
                ref_pos   = REF_BITS'(clamp_add(64'(ref_pos), 64'(len), 64'(REF_MAX)));
                read_pos  = READ_BITS'(clamp_add(64'(read_pos), 64'(len), 64'(READ_MAX)));
                match_len = READ_BITS'(clamp_add(64'(match_len), 64'(len), 64'(READ_MAX)));
            end
            CH_I: begin
                op       = OP_INS;
                read_pos = READ_BITS'(clamp_add(64'(read_pos), 64'(len), 64'(READ_MAX)));
            end
            CH_D: begin
                op      = OP_DEL;
                ref_pos = REF_BITS'(clamp_add(64'(ref_pos), 64'(len), 64'(REF_MAX)));
            end
            CH_S: begin
                op       = OP_SOFT;
                read_pos = READ_BITS'(clamp_add(64'(read_pos), 64'(len), 64'(READ_MAX)));
            end
            CH_H: begin
                op = OP_HARD;
            end
            default: begin
                op = OP_OTHER;
            end
        endcase
        seg.op_code       = op;
        seg.matched_total = match_len;
        return 1'b1;
    endfunction

    function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_segment(cawu_out_t want, cawu_out_t got);
        report_field("op_code", 32'(want.op_code), 32'(got.op_code));
        report_field("op_length", 32'(want.op_length), 32'(got.op_length));
        report_field("seg_ref_start", want.seg_ref_start, got.seg_ref_start);
        report_field("seg_read_offset", 32'(want.seg_read_offset), 32'(got.seg_read_offset));
        report_field("matched_total", 32'(want.matched_total), 32'(got.matched_total));
    endfunction

    // Offers one character word after a random gap and waits for acceptance.
    task automatic offer_char(cawu_in_t w, bit typed, cawu_out_t seg);
        char_item_t item;
        int         gap;
        gap = 0;
        while (gap < 8 && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        item.word  = w;
        item.typed = typed;
        item.seg   = seg;
        append_char_item(item);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        chars_sent++;
    endtask

    task automatic offer_plain(logic [7:0] ch, bit first, logic [31:0] start);
        cawu_in_t w;
        w.cigar_char     = ch;
        w.new_read       = first;
        w.read_ref_start = first ? start : $urandom;
        offer_char(w, 1'b0, '0);
    endtask

    // One random read: mostly well-formed number and letter pairs, with some
    // stray bytes, empty and long numbers, and an occasional dangling number.
    task automatic send_random_read();
        logic [31:0] start;
        bit          first;
        int          n_ops;
        int          n_digits;
        int          pick;
        case ($urandom_range(3))
            0: start = $urandom;
            1: start = 32'hFFFF_FFFF - $urandom_range(2000);
            default: start = $urandom_range(100000);
        endcase
        first = 1'b1;
        n_ops = $urandom_range(1, 8);
        repeat (n_ops) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                n_digits = 0;
            end else if (pick < 92) begin
                n_digits = $urandom_range(1, 3);
            end else begin
                n_digits = $urandom_range(4, 8);
            end
            repeat (n_digits) begin
                offer_plain(CH_ZERO + 8'($urandom_range(9)), first, start);
                first = 1'b0;
                if ($urandom_range(99) < 3) begin
                    offer_plain(8'($urandom_range(255)), 1'b0, start);
                end
            end
            if ($urandom_range(99) < 85) begin
                offer_plain(op_letters[$urandom_range(4)], first, start);
            end else begin
                offer_plain(8'($urandom_range(255)), first, start);
            end
            first = 1'b0;
        end
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 3)) offer_plain(CH_ZERO + 8'($urandom_range(9)), 1'b0, start);
        end
    endtask

    // Result side: random idling plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (long_hold_req && !long_hold_done) begin
            m_ready        <= 1'b0;
            hold_left      <= HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Predicts on every accepted character and checks every accepted segment.
    always @(posedge aclk) begin
        char_item_t item;
        cawu_out_t  seg;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                item = in_flight.pop_front();
                if (walk_cigar_char(item.word, seg)) begin
                    append_segment(item.typed ? item.seg : seg);
                end
            end
            if (m_valid && m_ready) begin
                if (expected_segments.size() == 0) begin
                    $display("%0t: unexpected segment word, expected none, actual %h",
                             $time, m_data);
                    mismatches++;
                end else begin
                    check_segment(expected_segments.pop_front(), m_data);
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles = stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("cigar_alignment_walker_unit test failed");
            $finish;
        end
    end

    initial begin
        cawu_in_t w;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Sender idles lightly, receiver heavily.
        send_idle_pct = 17;
        recv_idle_pct <= 72;
        foreach (directed_rows[i]) begin
            w.cigar_char     = directed_rows[i].ch;
            w.new_read       = directed_rows[i].first;
            w.read_ref_start = directed_rows[i].start;
            offer_char(w, directed_rows[i].typed, directed_rows[i].seg);
        end
        while (chars_sent < 275) send_random_read();

        // Roles swapped.
        send_idle_pct = 72;
        recv_idle_pct <= 17;
        while (chars_sent < 525) send_random_read();

        // No idling, with one long hold-off on the result side.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        long_hold_req <= 1'b1;
        while (chars_sent < 775) send_random_read();
        s_valid <= 1'b0;

        while (expected_segments.size() != 0 || in_flight.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("cigar_alignment_walker_unit test passed");
        end else begin
            $display("cigar_alignment_walker_unit test failed");
        end
        $finish;
    end

endmodule
